[rtl/fcwep_pkg.sv]
`default_nettype none
package fcwep_pkg;

  // field widths
  localparam int MAX_TAPS_DEF = 31;
  localparam int SAMPLE_W     = 16;
  localparam int WEIGHT_W     = 16;
  localparam int OUT_W        = 32;
  localparam int TIDX_W       = 5;
  localparam int COUNT_W      = 6;
  localparam int COUNT_MAX    = 63;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_VALUE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_SHIFT = 2'd3;

  // padding modes
  localparam logic [1:0] PAD_ZERO   = 2'd0;
  localparam logic [1:0] PAD_CONST  = 2'd1;
  localparam logic [1:0] PAD_MIRROR = 2'd2;

  // item kinds
  localparam logic ITEM_COEF   = 1'b0;
  localparam logic ITEM_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [TIDX_W-1:0]          tap_index;
    logic signed [WEIGHT_W-1:0] tap_weight;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       end_of_signal;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered_value;
    logic                    last_of_signal;
    logic                    too_short;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/fir_convolve_with_edge_padding.sv]
`default_nettype none
// a sample that releases an output starts one pass over the m taps in use (m = taps in use); out_valid
//   rises once the products are flushed; the end-of-signal sample releases up to m/2+1 outputs,
//   one pass each, all through the single shared multiply-accumulate
// coefficient items are taken while idle; inputs are stalled while outputs are computed
// reset clears the sample line, counters and accumulator and loads the configuration defaults;
//   the tap store is undefined until written
module fir_convolve_with_edge_padding
  import fcwep_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TI_W  = $clog2(MAX_TAPS);
  localparam int MW    = $clog2(MAX_TAPS + 1);
  localparam int D_W   = COUNT_W + MW + 3;
  localparam int ACC_W = SAMPLE_W + WEIGHT_W + MW;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_FLUSH = 5'b00100,
    ST_OUT   = 5'b01000,
    ST_SPARE = 5'b10000
  } state_t;

  state_t state_r;

  // configuration registers
  logic [4:0]                 tap_count_r;
  logic [1:0]                 pad_mode_r;
  logic signed [SAMPLE_W-1:0] pad_value_r;
  logic [4:0]                 shift_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= 5'd1;
      pad_mode_r  <= PAD_ZERO;
      pad_value_r <= '0;
      shift_r     <= 5'd14;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TAP_COUNT:    tap_count_r <= cfg_data[4:0];
        CFG_PADDING_MODE: pad_mode_r  <= cfg_data[1:0];
        CFG_PAD_VALUE:    pad_value_r <= $signed(cfg_data[SAMPLE_W-1:0]);
        CFG_RESULT_SHIFT: shift_r     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective window length and half width
  logic [MW-1:0] m_eff;
  logic [MW-1:0] h_eff;

  always_comb begin
    if (tap_count_r == 5'd0) begin
      m_eff = MW'(1);
    end else if (int'(tap_count_r) > MAX_TAPS) begin
      m_eff = MW'(MAX_TAPS);
    end else begin
      m_eff = MW'(tap_count_r);
    end
    h_eff = m_eff >> 1;
  end

  logic in_acc;
  logic smp_acc;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign smp_acc  = in_acc && (in_data.mode == ITEM_SAMPLE);

  // sample line: a row of delay cells, cell 0 newest
  logic signed [SAMPLE_W-1:0] line_q [MAX_TAPS];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TAPS; gi++) begin : g_line
      if (gi == 0) begin : g_head
        fcwep_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (smp_acc),
          .d_in     (in_data.sample_value),
          .q        (line_q[gi])
        );
      end else begin : g_body
        fcwep_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (smp_acc),
          .d_in     (line_q[gi-1]),
          .q        (line_q[gi])
        );
      end
    end
  endgenerate

  // tap store, no reset
  logic signed [WEIGHT_W-1:0] tap_r [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.mode == ITEM_COEF) && (int'(in_data.tap_index) < MAX_TAPS)) begin
      tap_r[TI_W'(in_data.tap_index)] <= in_data.tap_weight;
    end
  end

  // sequencer registers
  logic [COUNT_W-1:0] seen_r;
  logic [COUNT_W-1:0] done_r;
  logic [MW-1:0]      k_r;
  logic [TI_W-1:0]    j_r;
  logic               fl_r;
  logic               short_r;

  logic [COUNT_W-1:0] seen_sat;
  logic [COUNT_W-1:0] newest_new;
  logic [COUNT_W-1:0] done_sat;

  always_comb begin
    seen_sat   = (int'(seen_r) < COUNT_MAX) ? seen_r + 1'b1 : seen_r;
    newest_new = seen_sat - 1'b1;
    done_sat   = (int'(done_r) < COUNT_MAX) ? done_r + 1'b1 : done_r;
  end

  // neighbor selection for the tap being issued
  logic signed [D_W-1:0] i_s, k_s, d_s, idx_s, pos_s, p_s, newest_s;
  logic                  use_line;
  logic signed [SAMPLE_W-1:0] tap_val;

  always_comb begin
    i_s      = $signed(D_W'(done_r));
    k_s      = $signed(D_W'(k_r));
    d_s      = $signed(D_W'(j_r)) - $signed(D_W'(h_eff));
    idx_s    = i_s + d_s;
    newest_s = i_s + k_s;
    pos_s    = '0;
    p_s      = '0;
    use_line = 1'b0;
    tap_val  = '0;
    if (idx_s >= 0 && d_s <= k_s) begin
      pos_s    = k_s - d_s;
      use_line = 1'b1;
    end else if (pad_mode_r == PAD_CONST) begin
      tap_val = pad_value_r;
    end else if (pad_mode_r == PAD_MIRROR) begin
      if (idx_s < 0) begin
        pos_s = i_s + i_s + k_s + d_s;
        p_s   = -idx_s;
      end else begin
        pos_s = d_s - k_s - $signed(D_W'(1));
        p_s   = newest_s - pos_s;
      end
      use_line = (p_s >= 0) && (p_s <= newest_s);
    end
    if (use_line) begin
      if (pos_s >= 0 && pos_s < $signed(D_W'(MAX_TAPS))) begin
        tap_val = line_q[pos_s[TI_W-1:0]];
      end else begin
        tap_val = '0;
      end
    end
  end

  // multiply-accumulate pipeline: operands, product, sum
  logic signed [SAMPLE_W-1:0]          v_r;
  logic signed [WEIGHT_W-1:0]          w_r;
  logic                                v1_r;
  logic signed [SAMPLE_W+WEIGHT_W-1:0] p_r;
  logic                                pv_r;
  logic signed [ACC_W-1:0]             acc_r;

  always_ff @(posedge clk) begin
    v_r <= tap_val;
    w_r <= tap_r[j_r];
    p_r <= v_r * w_r;
  end

  // finishing shift and saturation
  logic signed [OUT_W-1:0] fin;

  fcwep_round #(.ACC_W(ACC_W)) u_round (
    .acc    (acc_r),
    .shift  (shift_r),
    .result (fin)
  );

  // control
  state_t    state_nxt;
  out_item_t out_r;

  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= '0;
      done_r  <= '0;
      k_r     <= '0;
      j_r     <= '0;
      fl_r    <= 1'b0;
      short_r <= 1'b0;
      v1_r    <= 1'b0;
      pv_r    <= 1'b0;
      acc_r   <= '0;
    end else begin
      v1_r <= (state_r == ST_MAC);
      pv_r <= v1_r;
      if (pv_r) begin
        acc_r <= acc_r + ACC_W'(p_r);
      end
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (smp_acc) begin
            seen_r  <= seen_sat;
            fl_r    <= in_data.end_of_signal;
            short_r <= int'(seen_sat) < int'(m_eff);
            j_r     <= '0;
            acc_r   <= '0;
            if (in_data.end_of_signal && (int'(newest_new) < int'(h_eff))) begin
              k_r <= MW'(newest_new);
            end else begin
              k_r <= h_eff;
            end
          end
        end
        ST_MAC: begin
          j_r <= j_r + 1'b1;
        end
        ST_FLUSH: begin
          if (!v1_r && !pv_r) begin
            out_r.filtered_value <= fin;
            out_r.last_of_signal <= fl_r && (k_r == '0);
            out_r.too_short      <= fl_r && (k_r == '0) && short_r;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (fl_r && (k_r != '0)) begin
              done_r <= done_sat;
              k_r    <= k_r - 1'b1;
              j_r    <= '0;
              acc_r  <= '0;
            end else if (fl_r) begin
              seen_r <= '0;
              done_r <= '0;
            end else begin
              done_r <= done_sat;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (smp_acc) begin
          if (in_data.end_of_signal || (int'(newest_new) >= int'(h_eff))) begin
            state_nxt = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (int'(j_r) == int'(m_eff) - 1) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!v1_r && !pv_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = (fl_r && (k_r != '0)) ? ST_MAC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // checks
  a_tap_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (int'(j_r) < int'(m_eff)))
    else $error("tap index past the window");

  a_k_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (k_r <= h_eff))
    else $error("lookahead beyond half window");

  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (!v1_r && !pv_r))
    else $error("result shown with products in flight");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last_of_signal) |=>
      (seen_r == '0 && done_r == '0 && state_r == ST_IDLE))
    else $error("counters not cleared after last transaction");

endmodule
`default_nettype wire

[rtl/fcwep_cell.sv]
`default_nettype none
module fcwep_cell
  import fcwep_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       shift_en,
  input  wire logic signed [SAMPLE_W-1:0] d_in,
  output logic signed [SAMPLE_W-1:0]      q
);

  logic signed [SAMPLE_W-1:0] q_r;

  // one delay element of the sample line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

[rtl/fcwep_round.sv]
`default_nettype none
module fcwep_round
  import fcwep_pkg::*;
#(
  parameter int ACC_W = 38
) (
  input  wire logic signed [ACC_W-1:0] acc,
  input  wire logic [4:0]              shift,
  output logic signed [OUT_W-1:0]      result
);

  logic signed [ACC_W:0] rnd;
  logic signed [ACC_W:0] sum;
  logic signed [ACC_W:0] shifted;

  // rounding right shift then saturation to the output width
  always_comb begin
    rnd = $signed((ACC_W+1)'(1) << shift) >>> 1;
    rnd = $signed({1'b0, rnd[ACC_W-1:0]});
    sum = $signed({acc[ACC_W-1], acc}) + rnd;
    shifted = sum >>> shift;
    if (shifted > $signed((ACC_W+1)'({1'b0, {(OUT_W-1){1'b1}}}))) begin
      result = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (shifted < -$signed((ACC_W+1)'({1'b1, {(OUT_W-1){1'b0}}}))) begin
      result = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      result = shifted[OUT_W-1:0];
    end
  end

endmodule
`default_nettype wire

[bench/fir_convolve_with_edge_padding_tb.sv]
`timescale 1ns / 100ps
module fir_convolve_with_edge_padding_tb;
  import fcwep_pkg::*;

  localparam int NTAPS = MAX_TAPS_DEF;
  localparam int SETTLE_CYCLES = 2 * NTAPS + 20;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // filter model state
  logic signed [WEIGHT_W-1:0] tap_words [NTAPS];
  logic signed [SAMPLE_W-1:0] delay_line [NTAPS];
  int samples_in_signal;
  int outputs_in_signal;
  logic [4:0] taps_reg;
  logic [1:0] pad_mode_reg;
  logic signed [SAMPLE_W-1:0] pad_reg;
  logic [4:0] shift_reg;

  out_item_t filtered_q [$];
  int error_count;
  int samples_sent;
  int coefs_sent;
  int results_checked;
  int cfg_writes;

  // sender burst control and receiver stall pattern
  int burst_left;
  int gap_max;
  int stall_pct;
  int hold_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  fir_convolve_with_edge_padding u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint line_at(int pos);
    if (pos < 0 || pos >= NTAPS) return 0;
    return longint'(delay_line[pos]);
  endfunction

  // one output of the centred window, newest usable sample k positions later
  function automatic logic signed [OUT_W-1:0] window_sum(int m, int k);
    int h, i, newest, d, idx, pos, p;
    longint acc, v, r;
    h = m / 2;
    i = outputs_in_signal;
    newest = i + k;
    acc = 0;
    for (int j = 0; j < m; j++) begin
      d = j - h;
      idx = i + d;
      v = 0;
      if (idx >= 0 && d <= k) begin
        v = line_at(k - d);
      end else if (pad_mode_reg == PAD_CONST) begin
        v = longint'(pad_reg);
      end else if (pad_mode_reg == PAD_MIRROR) begin
        pos = (idx < 0) ? (2 * i + k + d) : (d - k - 1);
        p = (idx < 0) ? -idx : (newest - pos);
        if (p >= 0 && p <= newest) v = line_at(pos);
      end
      acc += v * longint'(tap_words[j]);
    end
    if (shift_reg > 0) r = (acc + (64'sd1 <<< (shift_reg - 1))) >>> shift_reg;
    else r = acc;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[OUT_W-1:0];
  endfunction

  function automatic void push_output(int m, int k, logic last, logic short_flag);
    out_item_t o;
    o.filtered_value = window_sum(m, k);
    o.last_of_signal = last;
    o.too_short = short_flag;
    filtered_q.push_back(o);
    if (outputs_in_signal < COUNT_MAX) outputs_in_signal++;
  endfunction

  // update the model for one accepted transaction
  function automatic void predict_item(in_item_t it);
    int m, h, n, k;
    logic short_sig;
    if (it.mode == ITEM_COEF) begin
      if (it.tap_index < NTAPS) tap_words[it.tap_index] = it.tap_weight;
      return;
    end
    m = (taps_reg < 1) ? 1 : taps_reg;
    h = m / 2;
    for (int p = NTAPS - 1; p > 0; p--) delay_line[p] = delay_line[p - 1];
    delay_line[0] = it.sample_value;
    if (samples_in_signal < COUNT_MAX) samples_in_signal++;
    n = samples_in_signal;
    if (!it.end_of_signal) begin
      if (n - 1 >= h) push_output(m, h, 1'b0, 1'b0);
      return;
    end
    short_sig = n < m;
    k = (n - 1 < h) ? n - 1 : h;
    for (; k >= 0; k--) push_output(m, k, k == 0, k == 0 && short_sig);
    samples_in_signal = 0;
    outputs_in_signal = 0;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        error_count++;
      end else begin
        e = filtered_q.pop_front();
        results_checked++;
        if (out_data.filtered_value !== e.filtered_value) begin
          $display("%0t: filtered_value expected %0d actual %0d", $time,
                   e.filtered_value, out_data.filtered_value);
          error_count++;
        end
        if (out_data.last_of_signal !== e.last_of_signal) begin
          $display("%0t: last_of_signal expected %0b actual %0b", $time,
                   e.last_of_signal, out_data.last_of_signal);
          error_count++;
        end
        if (out_data.too_short !== e.too_short) begin
          $display("%0t: too_short expected %0b actual %0b", $time,
                   e.too_short, out_data.too_short);
          error_count++;
        end
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // send one transaction, then maybe leave a gap
  task automatic send_item(in_item_t it);
    in_data = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_item(it);
    if (it.mode == ITEM_COEF) coefs_sent++;
    else samples_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(8);
      if (gap_max > 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TAP_COUNT: taps_reg = val[4:0];
      CFG_PADDING_MODE: pad_mode_reg = val[1:0];
      CFG_PAD_VALUE: pad_reg = val;
      default: shift_reg = val[4:0];
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_coef(logic [TIDX_W-1:0] idx, logic [WEIGHT_W-1:0] w);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.mode = ITEM_COEF;
    it.tap_index = idx;
    it.tap_weight = w;
    send_item(it);
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] s, logic eos);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.mode = ITEM_SAMPLE;
    it.sample_value = s;
    it.end_of_signal = eos;
    send_item(it);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_signal(int len);
    for (int s = 0; s < len; s++) begin
      if ($urandom_range(19) == 0) send_coef(5'($urandom), 16'($urandom));
      send_sample(rand_sample(), s == len - 1);
    end
  endtask

  task automatic set_filter(int taps, int pmode, int pad, int shift);
    cfg_write(CFG_TAP_COUNT, {11'($urandom_range(2047)), 5'(taps)});
    cfg_write(CFG_PADDING_MODE, {14'($urandom_range(16383)), 2'(pmode)});
    cfg_write(CFG_PAD_VALUE, 16'(pad));
    cfg_write(CFG_RESULT_SHIFT, {11'($urandom_range(2047)), 5'(shift)});
  endtask

  // fill every tap before any sample; a write past the store is ignored
  task automatic test_load_taps();
    send_coef(5'd0, 16'h8000);
    send_coef(5'd1, 16'h7fff);
    for (int t = 2; t < NTAPS; t++) send_coef(5'(t), 16'($urandom));
    send_coef(5'd31, 16'($urandom));
  endtask

  task automatic test_directed();
    send_sample(16'h7fff, 1'b1);
    set_filter(5, PAD_ZERO, 0, 14);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hffff, 1'b1);
    set_filter(5, PAD_CONST, -32768, 0);
    send_sample(16'h1234, 1'b0);
    send_sample(16'h7fff, 1'b1);
    set_filter(7, PAD_MIRROR, 0, 31);
    send_sample(16'h0100, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b1);
    cfg_write(CFG_PADDING_MODE, 16'd3);
    send_sample(16'h4000, 1'b0);
    send_sample(16'hc000, 1'b1);
    // zero taps acts as one tap
    set_filter(0, PAD_MIRROR, 32767, 1);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b1);
    // widest window with no shift drives the sum into saturation
    for (int t = 0; t < NTAPS; t++) send_coef(5'(t), 16'h7fff);
    set_filter(31, PAD_CONST, 32767, 0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b1);
    for (int t = 0; t < NTAPS; t++) send_coef(5'(t), 16'h8000);
    send_sample(16'h7fff, 1'b1);
  endtask

  task automatic test_long_signal();
    set_filter(7, PAD_MIRROR, 0, 14);
    send_signal(70);
  endtask

  task automatic test_backpressure();
    set_filter(9, PAD_CONST, $urandom, 12);
    wait_idle();
    hold_cycles = 400;
    send_signal(20);
  endtask

  task automatic test_random();
    int taps;
    while (samples_sent + coefs_sent < 500) begin
      case ($urandom_range(9))
        0: taps = 31;
        1: taps = 0;
        2: taps = $urandom_range(31);
        default: taps = $urandom_range(9, 1);
      endcase
      set_filter(taps, $urandom_range(3), $urandom, $urandom_range(31));
      stall_pct = $urandom_range(3) * 25;
      gap_max = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if ($urandom_range(3) == 0)
        for (int t = 0; t < NTAPS; t++) send_coef(5'(t), 16'($urandom));
      repeat ($urandom_range(4, 1)) send_signal($urandom_range(20, 1));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TAP_COUNT;
    cfg_data = '0;
    out_stall = 1'b0;
    error_count = 0;
    samples_sent = 0;
    coefs_sent = 0;
    results_checked = 0;
    cfg_writes = 0;
    burst_left = 0;
    gap_max = 3;
    stall_pct = 30;
    hold_cycles = 0;
    taps_reg = 5'd1;
    pad_mode_reg = PAD_ZERO;
    pad_reg = '0;
    shift_reg = 5'd14;
    samples_in_signal = 0;
    outputs_in_signal = 0;
    for (int t = 0; t < NTAPS; t++) begin
      tap_words[t] = '0;
      delay_line[t] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_load_taps();
    test_directed();
    test_long_signal();
    test_backpressure();
    test_random();
    wait_idle();

    $display("covered %0d samples and %0d coefficient words, %0d filtered outputs checked",
             samples_sent, coefs_sent, results_checked);
    $display("across %0d register writes of tap count, padding, pad value and shift",
             cfg_writes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", filtered_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
rtl/fcwep_pkg.sv
rtl/fcwep_cell.sv
rtl/fcwep_round.sv
rtl/fir_convolve_with_edge_padding.sv
bench/fir_convolve_with_edge_padding_tb.sv
